FILE: hdl/tfp_pkg.sv
package tfp_pkg;

   localparam int FRAME_BYTES_DEF = 16;
   localparam int NODE_ID_POS     = 3;

   localparam logic [7:0] HEADER_RESET   = 8'h57;
   localparam logic [3:0] DIST_OFF_RESET = 4'd8;
   localparam logic [3:0] STR_OFF_RESET  = 4'd12;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER   = 2'd0,
      CSR_DIST_OFF = 2'd1,
      CSR_STR_OFF  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0]         node_id;
      logic signed [23:0] distance_mm;
      logic [15:0]        signal_strength;
   } tfp_result_type;

endpackage

FILE: hdl/tfp_if.sv
interface tfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfp_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         node_id;
   logic signed [23:0] distance_mm;
   logic [15:0]        signal_strength;

   modport source (output valid, output node_id, output distance_mm,
                   output signal_strength, input ready);
   modport sink   (input valid, input node_id, input distance_mm,
                   input signal_strength, output ready);
endinterface

FILE: hdl/tfp_frame_line.sv
module tfp_frame_line
   import tfp_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic           clock,
   input  logic           shift_en,
   input  logic [7:0]     rx_byte,
   input  logic [3:0]     dist_off,
   input  logic [3:0]     str_off,
   output tfp_result_type fields
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam int POS_W = ((IDX_W > 4) ? IDX_W : 4) + 1;

   typedef logic [7:0] line_type [FRAME_BYTES];

   line_type line_ff;
   line_type line_in;

   logic [POS_W-1:0] dist_pos;
   logic [POS_W-1:0] str_pos;

   function automatic logic [7:0] pick(input line_type ln, input logic [POS_W-1:0] pos);
      logic [7:0] val;
      val = 8'd0;
      if (pos < POS_W'(FRAME_BYTES)) begin
         val = ln[pos[IDX_W-1:0]];
      end
      return val;
   endfunction

   // frame bytes shift toward index 0, so after the last word byte p sits at p
   always_comb begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         line_in[i] = line_ff[i+1];
      end
      line_in[FRAME_BYTES-1] = rx_byte;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         line_ff <= line_in;
      end
   end

   assign dist_pos = POS_W'(dist_off);
   assign str_pos  = POS_W'(str_off);

   always_comb begin
      fields.node_id         = line_in[NODE_ID_POS];
      fields.distance_mm     = {pick(line_in, dist_pos + POS_W'(2)),
                                pick(line_in, dist_pos + POS_W'(1)),
                                pick(line_in, dist_pos)};
      fields.signal_strength = {pick(line_in, str_pos + POS_W'(1)),
                                pick(line_in, str_pos)};
   end

endmodule

FILE: hdl/tof_frame_parser.sv
// channel | dir | payload                                    | handshake
// req     | in  | rx_byte                                    | valid/ready
// rsp     | out | node_id, distance_mm, signal_strength      | valid/ready
// csr     | in  | csr_index, csr_wdata                       | csr_we, no wait
//
// one word is taken every cycle while no result is held on rsp; each word passes an input
// register and is worked on from there against the frame shift line
// a result word passes the input register and then the output register after the checksum word is taken
// reset is synchronous: it restores the register defaults and returns to the header hunt
// a result held on rsp stalls the input register, which then drops req.ready
module tof_frame_parser
   import tfp_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tfp_req_if.sink               req,
   tfp_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(FRAME_BYTES);
   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_BYTES - 1);

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_MARK    = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type      phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]     sum_ff, sum_in;
   logic [7:0]     header_ff;
   logic [3:0]     dist_off_ff;
   logic [3:0]     str_off_ff;
   logic           in_vld_ff, in_vld_in;
   logic [7:0]     in_byte_ff;
   logic           out_vld_ff, out_vld_in;
   tfp_result_type out_ff;
   tfp_result_type fields;

   logic advance;
   logic shift_en;
   logic emit;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || advance;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      shift_en = 1'b0;
      emit     = 1'b0;
      if (advance) begin
         unique case (phase_ff)
            PH_MARK: begin
               shift_en = 1'b1;
               count_in = count_ff + CNT_W'(1);
               sum_in   = sum_ff + in_byte_ff;
               phase_in = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               shift_en = 1'b1;
               if (count_ff != LAST_POS) begin
                  count_in = count_ff + CNT_W'(1);
                  sum_in   = sum_ff + in_byte_ff;
               end else begin
                  phase_in = PH_HUNT;
                  emit     = (in_byte_ff == sum_ff);
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (in_byte_ff == header_ff) begin
                  shift_en = 1'b1;
                  count_in = CNT_W'(1);
                  sum_in   = in_byte_ff;
                  phase_in = PH_MARK;
               end
            end
         endcase
      end
   end

   assign in_vld_in  = (req.valid && req.ready) || (in_vld_ff && !advance);
   assign out_vld_in = (advance && emit) || (out_vld_ff && !rsp.ready);

   tfp_frame_line #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_line (
      .clock    (clock),
      .shift_en (shift_en),
      .rx_byte  (in_byte_ff),
      .dist_off (dist_off_ff),
      .str_off  (str_off_ff),
      .fields   (fields)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         count_ff    <= '0;
         sum_ff      <= '0;
         header_ff   <= HEADER_RESET;
         dist_off_ff <= DIST_OFF_RESET;
         str_off_ff  <= STR_OFF_RESET;
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_HEADER:   header_ff   <= csr_wdata;
               CSR_DIST_OFF: dist_off_ff <= csr_wdata[3:0];
               CSR_STR_OFF:  str_off_ff  <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.rx_byte;
      end
      if (advance && emit) begin
         out_ff <= fields;
      end
   end

   assign rsp.valid           = out_vld_ff;
   assign rsp.node_id         = out_ff.node_id;
   assign rsp.distance_mm     = out_ff.distance_mm;
   assign rsp.signal_strength = out_ff.signal_strength;

endmodule

FILE: hdl/tfp_checker.sv
module tfp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [7:0]        rsp_node_id,
   input logic signed [23:0] rsp_distance_mm,
   input logic [15:0]       rsp_signal_strength
);

   // no result word right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_node_id) &&
      $stable(rsp_distance_mm) && $stable(rsp_signal_strength))
      else $error("stalled result changed");

   // input back-pressure only comes from a stalled result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output stall");

   // a frame spans many words, so results never come back to back
   a_no_adjacent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("two result words in a row");

endmodule

bind tof_frame_parser tfp_checker u_tfp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req.valid),
   .req_ready           (req.ready),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_node_id         (rsp.node_id),
   .rsp_distance_mm     (rsp.distance_mm),
   .rsp_signal_strength (rsp.signal_strength)
);

FILE: tb/tb_top.sv
module tb_top;
   import tfp_pkg::*;

   localparam int FRAME_LEN            = FRAME_BYTES_DEF;
   localparam int DRAIN_CYCLES         = 4;
   localparam int HOLD_CYCLES          = 400;
   localparam int RANDOM_BYTES_PER_RUN = 230;
   localparam int LIMIT_CYCLES         = 200000;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      SEEK_HEADER   = 2'd0,
      SEEK_FUNCTION = 2'd1,
      IN_BODY       = 2'd2
   } hunt_phase_type;

   typedef enum logic [1:0] {
      FR_GOOD,
      FR_BAD_SUM,
      FR_HEADER_INSIDE,
      FR_HEADER_AS_SUM
   } frame_kind_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tfp_req_if req_ch ();
   tfp_rsp_if rsp_ch ();

   tof_frame_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [7:0]     cfg_header;
   logic [3:0]     cfg_dist_off;
   logic [3:0]     cfg_str_off;
   hunt_phase_type hunt_phase;
   logic [4:0]     stored_count;
   logic [7:0]     frame_sum;
   logic [7:0]     frame_bytes [FRAME_LEN];

   logic [7:0]     rx_bytes [$];
   tfp_result_type frame_results [$];

   int send_idle_pct = 14;
   int recv_idle_pct = 62;
   logic hold_arm = 1'b0;
   logic rsp_hold = 1'b0;

   int mismatches       = 0;
   int bytes_queued     = 0;
   int bytes_taken      = 0;
   int results_checked  = 0;
   int settings_applied = 0;
   int cycle_count      = 0;

   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      mismatches++;
   endtask

   function automatic logic [7:0] stored_byte(input int pos);
      return (pos >= FRAME_LEN) ? 8'h00 : frame_bytes[pos];
   endfunction

   function automatic void store_frame_byte(input logic [7:0] b);
      if (stored_count < FRAME_LEN)
         frame_bytes[stored_count] = b;
      stored_count = stored_count + 5'd1;
   endfunction

   function automatic void parse_rx_byte(input logic [7:0] b);
      tfp_result_type word;
      int d;
      int s;
      case (hunt_phase)
         SEEK_FUNCTION: begin
            store_frame_byte(b);
            frame_sum  = frame_sum + b;
            hunt_phase = IN_BODY;
         end
         IN_BODY: begin
            if (int'(stored_count) + 1 < FRAME_LEN) begin
               store_frame_byte(b);
               frame_sum = frame_sum + b;
            end else begin
               // checksum word closes the frame
               store_frame_byte(b);
               hunt_phase = SEEK_HEADER;
               if (b == frame_sum) begin
                  d = int'(cfg_dist_off);
                  s = int'(cfg_str_off);
                  word.node_id         = stored_byte(NODE_ID_POS);
                  word.distance_mm     = {stored_byte(d + 2), stored_byte(d + 1),
                                          stored_byte(d)};
                  word.signal_strength = {stored_byte(s + 1), stored_byte(s)};
                  frame_results.push_back(word);
               end
            end
         end
         default: begin
            hunt_phase = SEEK_HEADER;
            if (b == cfg_header) begin
               stored_count = 5'd0;
               store_frame_byte(b);
               frame_sum  = b;
               hunt_phase = SEEK_FUNCTION;
            end
         end
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] b);
      rx_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_noise(input int count);
      int i;
      for (i = 0; i < count; i++)
         push_byte(8'($urandom));
   endtask

   task automatic queue_frame(input logic [7:0] node, input logic [23:0] dist_val,
                              input logic [15:0] strength, input frame_kind_type kind);
      logic [7:0] f [FRAME_LEN];
      logic [7:0] s;
      int i;
      int pos;
      for (i = 0; i < FRAME_LEN; i++)
         f[i] = 8'($urandom);
      for (i = 0; i < 3; i++) begin
         pos = int'(cfg_dist_off) + i;
         if (pos < FRAME_LEN - 1)
            f[pos] = dist_val[8*i +: 8];
      end
      for (i = 0; i < 2; i++) begin
         pos = int'(cfg_str_off) + i;
         if (pos < FRAME_LEN - 1)
            f[pos] = strength[8*i +: 8];
      end
      f[NODE_ID_POS] = node;
      f[0] = cfg_header;
      if (kind == FR_HEADER_INSIDE) begin
         f[1] = cfg_header;
         f[FRAME_LEN-2] = cfg_header;
      end
      s = 8'h00;
      for (i = 0; i < FRAME_LEN - 1; i++)
         s = s + f[i];
      case (kind)
         FR_BAD_SUM: f[FRAME_LEN-1] = s + 8'($urandom_range(1, 255));
         FR_HEADER_AS_SUM: begin
            // bad checksum that looks like a header
            if (s == cfg_header)
               f[FRAME_LEN-2] = f[FRAME_LEN-2] + 8'd1;
            f[FRAME_LEN-1] = cfg_header;
         end
         default: f[FRAME_LEN-1] = s;
      endcase
      for (i = 0; i < FRAME_LEN; i++)
         push_byte(f[i]);
   endtask

   task automatic queue_random_traffic(input int count);
      int start;
      int roll;
      start = bytes_queued;
      while (bytes_queued - start < count) begin
         roll = $urandom_range(99);
         if (roll < 70)
            queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_GOOD);
         else if (roll < 80)
            queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_BAD_SUM);
         else if (roll < 85)
            queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_HEADER_INSIDE);
         else if (roll < 88)
            queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_HEADER_AS_SUM);
         else if (roll < 93) begin
            // cut-off frame, the following words run into it
            push_byte(cfg_header);
            queue_noise($urandom_range(1, 13));
         end else
            queue_noise($urandom_range(1, 6));
      end
   endtask

   task automatic settle();
      @(posedge clock);
      while (rx_bytes.size() != 0 || req_ch.valid || frame_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_HEADER:   cfg_header   = value;
         CSR_DIST_OFF: cfg_dist_off = value[3:0];
         CSR_STR_OFF:  cfg_str_off  = value[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] header, input logic [7:0] dist_off,
                                 input logic [7:0] strength);
      write_reg(CSR_HEADER, header);
      write_reg(CSR_DIST_OFF, dist_off);
      write_reg(CSR_STR_OFF, strength);
      write_reg(CSR_IDX_UNUSED, 8'($urandom));
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.rx_byte <= 8'h00;
         hunt_phase      = SEEK_HEADER;
         stored_count    = 5'd0;
         frame_sum       = 8'h00;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            parse_rx_byte(req_ch.rx_byte);
            bytes_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (rx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid   <= 1'b1;
               req_ch.rx_byte <= rx_bytes.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      tfp_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frame_results.size() == 0) begin
               report_mismatch("result word with none pending", rsp_ch.distance_mm, 24'h0);
            end else begin
               want = frame_results.pop_front();
               results_checked++;
               if (rsp_ch.node_id !== want.node_id)
                  report_mismatch("node_id", 24'(rsp_ch.node_id), 24'(want.node_id));
               if (rsp_ch.distance_mm !== want.distance_mm)
                  report_mismatch("distance_mm", rsp_ch.distance_mm, want.distance_mm);
               if (rsp_ch.signal_strength !== want.signal_strength)
                  report_mismatch("signal_strength", 24'(rsp_ch.signal_strength),
                                  24'(want.signal_strength));
            end
         end
         rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long receiver hold-off so the parser backs up into its input
   initial begin
      wait (hold_arm);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int mode;
      int k;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_HEADER;
      csr_wdata      = 8'h00;
      cfg_header     = HEADER_RESET;
      cfg_dist_off   = DIST_OFF_RESET;
      cfg_str_off    = STR_OFF_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      queue_frame(8'h00, 24'h000000, 16'h0000, FR_GOOD);
      queue_frame(8'hFF, 24'h7FFFFF, 16'hFFFF, FR_GOOD);
      queue_frame(8'h5A, 24'h800000, 16'h0001, FR_GOOD);
      queue_frame(8'h01, 24'hFFFFFF, 16'h8000, FR_HEADER_INSIDE);
      queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_BAD_SUM);
      queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_HEADER_AS_SUM);
      queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_GOOD);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'hA8);
      queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_GOOD);
      settle();

      // offsets running past the frame end, then offsets at the frame start and at its end
      apply_settings(8'h00, 8'hFF, 8'hFE);
      queue_frame(8'($urandom), 24'h123456, 16'hBEEF, FR_GOOD);
      queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_GOOD);
      settle();
      apply_settings(8'hFF, 8'h0E, 8'hFF);
      queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_GOOD);
      queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_HEADER_INSIDE);
      settle();
      apply_settings(8'hA5, 8'h00, 8'h00);
      queue_frame(8'($urandom), 24'($urandom), 16'($urandom), FR_GOOD);
      settle();
      apply_settings(8'h3C, 8'hFD, 8'hFE);
      queue_frame(8'($urandom), 24'h800000, 16'h7FFF, FR_GOOD);
      settle();

      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 14;
               recv_idle_pct = 62;
            end
            1: begin
               send_idle_pct = 62;
               recv_idle_pct = 14;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (k = 0; k < 2; k++) begin
            apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
            if (mode == 2 && k == 0)
               hold_arm = 1'b1;
            queue_random_traffic(RANDOM_BYTES_PER_RUN);
            settle();
         end
      end

      $display("run covered %0d input words and %0d checked result words", bytes_taken,
               results_checked);
      $display("over %0d register settings, three idle mixes and one long output stall",
               settings_applied);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: tof_frame_parser.f
hdl/tfp_pkg.sv
hdl/tfp_if.sv
hdl/tfp_frame_line.sv
hdl/tof_frame_parser.sv
hdl/tfp_checker.sv
tb/tb_top.sv
